>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the rtl files, included by cpa_datapath
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define CPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define CPA_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/cpa_pkg.sv
// ---------------------------------------------------------------------------
// cpa_pkg
// shared types and constants of the circle packing acceptor
// ---------------------------------------------------------------------------
package cpa_pkg;

  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned SUM_W       = 42;
  localparam int unsigned CFG_W       = 42;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned REASON_W    = 3;
  localparam int unsigned COUNT_OUT_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_AREA = 2'd1;

  localparam logic [FIELD_W-1:0] DOMAIN_SIZE_RST = 16'd8192;
  localparam logic [SUM_W-1:0]   TARGET_AREA_RST = 42'd8544937;

  typedef enum logic [REASON_W-1:0] {
    RSN_NONE    = 3'd0,
    RSN_BOUNDS  = 3'd1,
    RSN_OVERLAP = 3'd2,
    RSN_FULL    = 3'd3,
    RSN_DONE    = 3'd4
  } reason_e;

  typedef struct packed {
    logic load;
    logic check;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pre_reject;
    logic store_empty;
    logic scan_last;
    logic pipe_empty;
    logic out_free;
  } status_t;

endpackage

>>> rtl/cpa_cand_if.sv
// ---------------------------------------------------------------------------
// cpa_cand_if
// candidate request channel: centre and radius of one circle
// ---------------------------------------------------------------------------
interface cpa_cand_if;
  logic                        valid;
  logic                        ready;
  logic [cpa_pkg::FIELD_W-1:0] cand_x;
  logic [cpa_pkg::FIELD_W-1:0] cand_y;
  logic [cpa_pkg::FIELD_W-1:0] cand_radius;

  modport source (output valid, output cand_x, output cand_y, output cand_radius,
                  input ready);
  modport sink   (input valid, input cand_x, input cand_y, input cand_radius,
                  output ready);
endinterface

>>> rtl/cpa_res_if.sv
// ---------------------------------------------------------------------------
// cpa_res_if
// result request channel: verdict on one candidate
// ---------------------------------------------------------------------------
interface cpa_res_if;
  logic                            valid;
  logic                            ready;
  logic                            accepted;
  logic [cpa_pkg::REASON_W-1:0]    reject_reason;
  logic                            packing_done;
  logic [cpa_pkg::COUNT_OUT_W-1:0] stored_count;

  modport source (output valid, output accepted, output reject_reason,
                  output packing_done, output stored_count, input ready);
  modport sink   (input valid, input accepted, input reject_reason,
                  input packing_done, input stored_count, output ready);
endinterface

>>> rtl/cpa_datapath.sv
// ---------------------------------------------------------------------------
// cpa_datapath
// circle store, overlap scan pipeline, area sum and result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpa_datapath #(
  parameter int unsigned MAX_CIRCLES = 1024,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [cpa_pkg::FIELD_W-1:0]         cand_x_i,
  input  logic [cpa_pkg::FIELD_W-1:0]         cand_y_i,
  input  logic [cpa_pkg::FIELD_W-1:0]         cand_radius_i,
  input  logic                                cfg_we_i,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cpa_pkg::CFG_W-1:0]           cfg_data_i,
  input  cpa_pkg::cmd_t                       cmd_i,
  output cpa_pkg::status_t                    status_o,
  input  logic                                res_ready_i,
  output logic                                res_valid_o,
  output logic                                accepted_o,
  output logic [cpa_pkg::REASON_W-1:0]        reject_reason_o,
  output logic                                packing_done_o,
  output logic [cpa_pkg::COUNT_OUT_W-1:0]     stored_count_o
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned FW    = cpa_pkg::FIELD_W;
  localparam int unsigned SW    = cpa_pkg::SUM_W;
  localparam int unsigned OW    = cpa_pkg::COUNT_OUT_W;
  localparam int unsigned AW    = $clog2(MAX_CIRCLES);
  localparam int unsigned CNT_W = $clog2(MAX_CIRCLES + 1);
  localparam int unsigned SQ_W  = 2 * CW;
  localparam int unsigned ACC_W = ((SQ_W > SW) ? SQ_W : SW) + 1;
  localparam int unsigned ENT_W = 3 * CW;

  // field to coordinate width conversion
  logic [CW+FW-1:0] x_ext, y_ext, r_ext, dom_ext, dom_rst_ext;
  assign x_ext       = {{CW{1'b0}}, cand_x_i};
  assign y_ext       = {{CW{1'b0}}, cand_y_i};
  assign r_ext       = {{CW{1'b0}}, cand_radius_i};
  assign dom_ext     = {{CW{1'b0}}, cfg_data_i[FW-1:0]};
  assign dom_rst_ext = {{CW{1'b0}}, cpa_pkg::DOMAIN_SIZE_RST};

  // configuration
  logic [CW-1:0] domain_q;
  logic [SW-1:0] target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      domain_q <= dom_rst_ext[CW-1:0];
      target_q <= cpa_pkg::TARGET_AREA_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cpa_pkg::REG_DOMAIN_SIZE: domain_q <= dom_ext[CW-1:0];
        cpa_pkg::REG_TARGET_AREA: target_q <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // candidate
  logic [CW-1:0]   x_q, y_q, r_q;
  logic [SQ_W-1:0] sq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= x_ext[CW-1:0];
      y_q <= y_ext[CW-1:0];
      r_q <= r_ext[CW-1:0];
    end
    sq_q <= r_q * r_q;
  end

  // control state
  logic [CNT_W-1:0] count_q, count_d;
  logic [SW-1:0]    sum_q, sum_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] idx_q;
  logic             hit_q;
  cpa_pkg::reason_e reason_q, pre_reason, fin_reason;

  // early checks
  logic [CW:0] x_hi, y_hi;
  logic        out_of_bounds, full;
  assign x_hi          = {1'b0, x_q} + {1'b0, r_q};
  assign y_hi          = {1'b0, y_q} + {1'b0, r_q};
  assign out_of_bounds = (x_q < r_q) || (y_q < r_q) ||
                         (x_hi > {1'b0, domain_q}) || (y_hi > {1'b0, domain_q});
  assign full          = (count_q == CNT_W'(MAX_CIRCLES));

  always_comb begin
    if (done_q)             pre_reason = cpa_pkg::RSN_DONE;
    else if (out_of_bounds) pre_reason = cpa_pkg::RSN_BOUNDS;
    else if (full)          pre_reason = cpa_pkg::RSN_FULL;
    else                    pre_reason = cpa_pkg::RSN_NONE;
  end

  // circle store
  logic [ENT_W-1:0] mem [MAX_CIRCLES];
  logic [ENT_W-1:0] rd_q;
  logic             mem_we;
  assign mem_we = cmd_i.finish && (fin_reason == cpa_pkg::RSN_NONE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= {x_q, y_q, r_q};
    end
    rd_q <= mem[idx_q[AW-1:0]];
  end

  // overlap scan pipeline
  logic              v1_q, v2_q, v3_q;
  logic [CW-1:0]     dx_q, dy_q;
  logic [CW:0]       rs_q;
  logic [SQ_W-1:0]   dx2_q, dy2_q;
  logic [SQ_W+1:0]   rs2_q;
  logic [CW-1:0]     sx, sy, sr;
  logic [SQ_W+1:0]   d2;
  assign sx = rd_q[ENT_W-1:2*CW];
  assign sy = rd_q[2*CW-1:CW];
  assign sr = rd_q[CW-1:0];
  assign d2 = (SQ_W+2)'(dx2_q) + (SQ_W+2)'(dy2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      idx_q <= '0;
      hit_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.check) begin
        idx_q <= '0;
      end else if (cmd_i.issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.check) begin
        hit_q <= 1'b0;
      end else if (v3_q && (d2 < rs2_q)) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= (sx >= x_q) ? (sx - x_q) : (x_q - sx);
    dy_q  <= (sy >= y_q) ? (sy - y_q) : (y_q - sy);
    rs_q  <= {1'b0, sr} + {1'b0, r_q};
    dx2_q <= dx_q * dx_q;
    dy2_q <= dy_q * dy_q;
    rs2_q <= rs_q * rs_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      reason_q <= pre_reason;
    end
  end

  // commit
  logic [ACC_W-1:0] sum_ext, sq_ext, sum_add, sum_max;
  logic [CNT_W+OW-1:0] cnt_ext;
  assign sum_ext = ACC_W'(sum_q);
  assign sq_ext  = ACC_W'(sq_q);
  assign sum_add = sum_ext + sq_ext;
  assign sum_max = ACC_W'({SW{1'b1}});

  always_comb begin
    if (reason_q != cpa_pkg::RSN_NONE) fin_reason = reason_q;
    else if (hit_q)                    fin_reason = cpa_pkg::RSN_OVERLAP;
    else                               fin_reason = cpa_pkg::RSN_NONE;
  end

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    done_d  = done_q;
    if (mem_we) begin
      count_d = count_q + CNT_W'(1);
      if ((sq_ext >= sum_max) || (sum_add > sum_max)) sum_d = {SW{1'b1}};
      else                                            sum_d = sum_add[SW-1:0];
      if (sum_d >= target_q) done_d = 1'b1;
    end
  end
  assign cnt_ext = {{OW{1'b0}}, count_d};

  logic                         res_valid_q;
  logic                         accepted_q;
  logic [cpa_pkg::REASON_W-1:0] reason_out_q;
  logic                         done_out_q;
  logic [OW-1:0]                count_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      done_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
      if (cmd_i.finish)     res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      accepted_q   <= mem_we;
      reason_out_q <= fin_reason;
      done_out_q   <= done_d;
      count_out_q  <= cnt_ext[OW-1:0];
    end
  end

  assign res_valid_o     = res_valid_q;
  assign accepted_o      = accepted_q;
  assign reject_reason_o = reason_out_q;
  assign packing_done_o  = done_out_q;
  assign stored_count_o  = count_out_q;

  assign status_o.pre_reject  = (pre_reason != cpa_pkg::RSN_NONE);
  assign status_o.store_empty = (count_q == '0);
  assign status_o.scan_last   = ((idx_q + CNT_W'(1)) == count_q);
  assign status_o.pipe_empty  = !(v1_q || v2_q || v3_q);
  assign status_o.out_free    = !res_valid_q || res_ready_i;

  `CPA_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(MAX_CIRCLES), "count beyond store")
  `CPA_ASSERT(a_done_sticky, clk_i, rst_ni, done_q |=> done_q, "done flag dropped")
  `CPA_ASSERT(a_store_inc, clk_i, rst_ni, mem_we |=> count_q == $past(count_q) + CNT_W'(1), "count not advanced")
  `CPA_NEVER(a_issue_range, clk_i, rst_ni, cmd_i.issue && (idx_q >= count_q), "scan past last circle")

endmodule

>>> rtl/cpa_ctrl.sv
// ---------------------------------------------------------------------------
// cpa_ctrl
// sequencer: check, scan of the store, commit of one candidate
// ---------------------------------------------------------------------------
module cpa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cand_valid_i,
  output logic             cand_ready_o,
  input  cpa_pkg::status_t status_i,
  output cpa_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cand_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cand_ready_o = 1'b1;
        if (cand_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.pre_reject || status_i.store_empty) state_d = ST_FINISH;
        else                                             state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/circle_packing_acceptor_top.sv
// ---------------------------------------------------------------------------
// circle_packing_acceptor_top
// random sequential addition circle packing acceptor
// ---------------------------------------------------------------------------
// Each candidate request is checked for done, domain bounds and a full store,
// then scanned against every stored circle through the single read port of
// the circle store, one stored circle per cycle into a four-stage distance
// pipeline. A candidate rejected early, or one arriving with the store empty,
// goes from the check straight to the finish state, others through the scan
// and a drain of the pipeline; the finish state waits while the previous
// result still waits in the output register. The result sits in that register,
// so the next candidate is taken while a result waits. The store needs no clearing pass.
module circle_packing_acceptor_top #(
  parameter int unsigned MAX_CIRCLES = 1024,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cpa_cand_if.sink                      cand,
  cpa_res_if.source                     res,
  input  logic                          cfg_we_i,
  input  logic [cpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cpa_pkg::CFG_W-1:0]     cfg_data_i
);

  cpa_pkg::cmd_t    cmd;
  cpa_pkg::status_t status;

  cpa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cand_valid_i (cand.valid),
    .cand_ready_o (cand.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  cpa_datapath #(
    .MAX_CIRCLES (MAX_CIRCLES),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cand_x_i        (cand.cand_x),
    .cand_y_i        (cand.cand_y),
    .cand_radius_i   (cand.cand_radius),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .res_ready_i     (res.ready),
    .res_valid_o     (res.valid),
    .accepted_o      (res.accepted),
    .reject_reason_o (res.reject_reason),
    .packing_done_o  (res.packing_done),
    .stored_count_o  (res.stored_count)
  );

endmodule

>>> tb/cpa_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpa_checker
// watches the candidate, result and register ports of the acceptor, keeps
// its own copy of the circle store, the area sum and the done flag, works
// out the verdict on every accepted candidate and compares each returned
// verdict, field by field, with the oldest one still owed
// ---------------------------------------------------------------------------
module cpa_checker #(
  parameter int unsigned MAX_CIRCLES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cpa_cand_if                           cand_mon,
  cpa_res_if                            res_mon,
  input  logic                          cfg_we_i,
  input  logic [cpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cpa_pkg::CFG_W-1:0]     cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o,
  output int unsigned                   stored_o,
  output logic                          packing_done_o
);
  import cpa_pkg::*;

  localparam logic [SUM_W-1:0] SUM_SAT = '1;

  typedef struct packed {
    logic                   accepted;
    reason_e                reason;
    logic                   packing_done;
    logic [COUNT_OUT_W-1:0] stored_count;
  } verdict_t;

  logic [FIELD_W-1:0] domain_side;
  logic [SUM_W-1:0]   area_target;
  logic [FIELD_W-1:0] circle_x [MAX_CIRCLES];
  logic [FIELD_W-1:0] circle_y [MAX_CIRCLES];
  logic [FIELD_W-1:0] circle_r [MAX_CIRCLES];
  int unsigned        circle_total;
  logic [SUM_W-1:0]   radius_sq_sum;
  logic               done_latched;
  verdict_t           verdicts_due [$];

  // squared distance strictly below squared radius sum, touching is allowed
  function automatic logic overlaps_circle(int unsigned k, logic [FIELD_W-1:0] x,
                                           logic [FIELD_W-1:0] y, logic [FIELD_W-1:0] r);
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] rsum;
    dx   = (circle_x[k] >= x) ? 64'(circle_x[k]) - 64'(x) : 64'(x) - 64'(circle_x[k]);
    dy   = (circle_y[k] >= y) ? 64'(circle_y[k]) - 64'(y) : 64'(y) - 64'(circle_y[k]);
    rsum = 64'(circle_r[k]) + 64'(r);
    return (dx * dx + dy * dy) < (rsum * rsum);
  endfunction

  function automatic verdict_t judge_candidate(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                               logic [FIELD_W-1:0] r);
    verdict_t    v;
    reason_e     why;
    logic [63:0] grown;
    int unsigned k;
    why = RSN_NONE;
    if (done_latched) begin
      why = RSN_DONE;
    end else if (x < r || y < r || 64'(x) + 64'(r) > 64'(domain_side) ||
                 64'(y) + 64'(r) > 64'(domain_side)) begin
      why = RSN_BOUNDS;
    end else if (circle_total >= MAX_CIRCLES) begin
      why = RSN_FULL;
    end else begin
      k = 0;
      while (k < circle_total && why == RSN_NONE) begin
        if (overlaps_circle(k, x, y, r)) why = RSN_OVERLAP;
        k++;
      end
    end
    if (why == RSN_NONE) begin
      circle_x[circle_total] = x;
      circle_y[circle_total] = y;
      circle_r[circle_total] = r;
      circle_total++;
      grown = 64'(radius_sq_sum) + 64'(r) * 64'(r);
      radius_sq_sum = (grown > 64'(SUM_SAT)) ? SUM_SAT : grown[SUM_W-1:0];
      if (radius_sq_sum >= area_target) done_latched = 1'b1;
    end
    v.accepted     = (why == RSN_NONE);
    v.reason       = why;
    v.packing_done = done_latched;
    v.stored_count = COUNT_OUT_W'(circle_total);
    return v;
  endfunction

  function automatic void note_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: verdict %0d field %s expected %0d got %0d",
               $time, checked_o, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      domain_side   = DOMAIN_SIZE_RST;
      area_target   = TARGET_AREA_RST;
      circle_total  = 0;
      radius_sq_sum = '0;
      done_latched  = 1'b0;
      verdicts_due.delete();
      fail_count_o  = 0;
      checked_o     = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (verdicts_due.size() == 0) begin
          fail_count_o++;
          $display("%0t: verdict with no candidate request outstanding", $time);
        end else begin
          verdict_t want;
          want = verdicts_due.pop_front();
          note_field("accepted", 16'(want.accepted), 16'(res_mon.accepted));
          note_field("reject_reason", 16'(want.reason), 16'(res_mon.reject_reason));
          note_field("packing_done", 16'(want.packing_done), 16'(res_mon.packing_done));
          note_field("stored_count", 16'(want.stored_count), 16'(res_mon.stored_count));
        end
        checked_o++;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DOMAIN_SIZE: domain_side = cfg_data_i[FIELD_W-1:0];
          REG_TARGET_AREA: area_target = cfg_data_i[SUM_W-1:0];
          default: ;
        endcase
      end
      if (cand_mon.valid && cand_mon.ready)
        verdicts_due.insert(verdicts_due.size(),
                            judge_candidate(cand_mon.cand_x, cand_mon.cand_y,
                                            cand_mon.cand_radius));
    end
    pending_o      = verdicts_due.size();
    stored_o       = circle_total;
    packing_done_o = done_latched;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// drives candidate circles and register writes into the packing acceptor:
// a directed set for bounds, touching, overlap and zero-target behavior,
// then random candidates, mostly placed inside the domain, under phases of
// sender idling and receiver stalls; the checker scores every verdict
// ---------------------------------------------------------------------------
module tb_top;
  import cpa_pkg::*;

  localparam int unsigned MAX_CIRCLES = 1024;
  localparam int unsigned STUCK_LIMIT = 20000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned DONE_ITEMS  = 40;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [FIELD_W-1:0]   SIDE_MAX    = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;
  int unsigned        hold_left;
  int unsigned        stuck_cycles;
  int unsigned        sent_total;
  logic               long_hold_req;
  logic [FIELD_W-1:0] side;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned stored;
  logic        packing_done;

  cpa_cand_if cand_ch ();
  cpa_res_if  res_ch ();

  circle_packing_acceptor_top #(
    .MAX_CIRCLES(MAX_CIRCLES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cand       (cand_ch),
    .res        (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  cpa_checker #(
    .MAX_CIRCLES(MAX_CIRCLES)
  ) verdict_mon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cand_mon      (cand_ch),
    .res_mon       (res_ch),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .stored_o      (stored),
    .packing_done_o(packing_done)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // result side: random stalls, or one long hold-off on request
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, stuck_cycles);
      $display("circle_packing_acceptor_top regression: fail");
      $finish;
    end else if ((cand_ch.valid && cand_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_cand(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                           logic [FIELD_W-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      cand_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cand_ch.valid       <= 1'b1;
    cand_ch.cand_x      <= x;
    cand_ch.cand_y      <= y;
    cand_ch.cand_radius <= r;
    @(posedge clk_i);
    while (!cand_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent_total++;
  endtask

  task automatic drain;
    cand_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_phase(int unsigned idle_pct, int unsigned stall_pct,
                           logic [FIELD_W-1:0] dom);
    drain();
    write_reg(REG_DOMAIN_SIZE, CFG_W'(dom));
    write_reg(REG_TARGET_AREA, {10'h3FF, 32'($urandom())});
    side           = dom;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // mostly in-domain circles, some noise and some just over an edge
  task automatic send_random;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] r;
    int unsigned        pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      x = FIELD_W'($urandom());
      y = FIELD_W'($urandom());
      r = FIELD_W'($urandom());
    end else begin
      if (pick < 60) r = FIELD_W'($urandom_range(300));
      else if (pick < 92) r = FIELD_W'($urandom_range(1500));
      else r = FIELD_W'($urandom_range(side / 2));
      if (32'(r) * 2 > 32'(side)) r = side / 2;
      x = FIELD_W'($urandom_range(side - r, r));
      y = FIELD_W'($urandom_range(side - r, r));
      if (pick < 16) begin
        if (pick[0]) x = side - r + FIELD_W'(1);
        else y = r - FIELD_W'(1);
      end else if (pick >= 88 && pick < 92) begin
        x = r;
        y = side - r;
      end
    end
    send_cand(x, y, r);
  endtask

  initial begin
    int unsigned i;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = REG_DOMAIN_SIZE;
    cfg_data_i          = '0;
    cand_ch.valid       = 1'b0;
    cand_ch.cand_x      = '0;
    cand_ch.cand_y      = '0;
    cand_ch.cand_radius = '0;
    res_ch.ready        = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_left           = 0;
    stuck_cycles        = 0;
    sent_total          = 0;
    long_hold_req       = 1'b0;
    side                = DOMAIN_SIZE_RST;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero target: nothing stored yet, so done stays low
    write_reg(REG_TARGET_AREA, '0);
    write_reg(REG_DOMAIN_SIZE, {26'h3FFFFFF, 16'h2000});
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, {21'h0AAAAA, 21'h155555});
    send_cand(16'd0, 16'd0, 16'd1);
    send_cand(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cand(16'd8193, 16'd100, 16'd0);
    send_cand(16'd100, 16'd8193, 16'd0);
    send_cand(16'd4096, 16'd8191, 16'd2);

    // empty domain: only a point at the origin fits
    drain();
    write_reg(REG_TARGET_AREA, '1);
    write_reg(REG_DOMAIN_SIZE, '0);
    send_cand(16'd0, 16'd0, 16'd0);
    send_cand(16'd1, 16'd0, 16'd0);
    send_cand(16'd0, 16'd0, 16'd0);

    // full-scale domain: corners, touching and overlapping circles
    drain();
    write_reg(REG_DOMAIN_SIZE, CFG_W'(SIDE_MAX));
    send_cand(16'd65535, 16'd65535, 16'd0);
    send_cand(16'd1000, 16'd1000, 16'd1000);
    send_cand(16'd3000, 16'd1000, 16'd1000);
    send_cand(16'd3000, 16'd3000, 16'd1000);
    send_cand(16'd2999, 16'd1001, 16'd1000);
    send_cand(16'd32767, 16'd32767, 16'd32767);
    send_cand(16'd32768, 16'd32768, 16'd32767);
    send_cand(16'd0, 16'd65535, 16'd0);
    send_cand(16'd65535, 16'd0, 16'd1);
    send_cand(16'd65534, 16'd1, 16'd1);

    // back-to-back requests, result side held off early on
    set_phase(0, 0, SIDE_MAX);
    long_hold_req = 1'b1;
    repeat (PHASE_ITEMS) send_random();

    set_phase(52, 0, FIELD_W'($urandom_range(65535, 20000)));
    for (i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2) drain();
      send_random();
    end

    set_phase(0, 52, 16'd40000);
    repeat (PHASE_ITEMS) send_random();

    set_phase(16, 16, SIDE_MAX);
    repeat (PHASE_ITEMS - DONE_ITEMS) send_random();

    // zero target: the next stored circle ends the packing
    drain();
    write_reg(REG_TARGET_AREA, '0);
    repeat (DONE_ITEMS) send_random();

    drain();
    repeat (MAX_CIRCLES + 16) @(posedge clk_i);

    $display("%0d candidates sent, %0d verdicts checked, %0d circles stored",
             sent_total, checked, stored);
    $display("domain side from 0 to full scale, area target from 0 to maximum, done %0d",
             packing_done);
    if (fail_count == 0 && pending == 0) begin
      $display("circle_packing_acceptor_top regression: pass");
    end else begin
      $display("circle_packing_acceptor_top regression: fail");
    end
    $finish;
  end

endmodule
